@@ sv/sast_pkg.sv @@
// Shared types, constants and helpers for the sector authentication session table.
package sast_pkg;

    localparam int MAX_SECTORS   = 40;
    localparam int TIME_WIDTH    = 20;
    localparam int LARGE_SECTORS = 40;
    localparam int SMALL_SECTORS = 16;
    localparam int SECT_W        = 6;
    localparam int FIELD_TIME_W  = 20;
    localparam int COUNT_W       = 7;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHING_ENABLED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_CARD      = 2'd2;

    typedef enum logic [3:0] {
        OP_MARK        = 4'd0,
        OP_INVALIDATE  = 4'd1,
        OP_CLEAR       = 4'd2,
        OP_QUERY       = 4'd3,
        OP_REFRESH     = 4'd4,
        OP_SET_TIMEOUT = 4'd5,
        OP_TICK        = 4'd6,
        OP_COUNT       = 4'd7,
        OP_PURGE       = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COUNT
    } t_state;

    typedef struct packed {
        logic                  exec;
        logic                  shift;
        logic                  clear_all;
        logic                  mark_ok;
        logic                  inval_ok;
        t_op                   op;
        logic [SECT_W-1:0]     sector;
        logic                  key;
        logic [TIME_WIDTH-1:0] timeout;
    } t_cell_cmd;

    typedef struct packed {
        logic                  valid;
        logic                  key;
        logic [TIME_WIDTH-1:0] countdown;
    } t_cell_rd;

    function automatic logic [TIME_WIDTH-1:0] to_time(input logic [FIELD_TIME_W-1:0] v);
        return TIME_WIDTH'(v);
    endfunction

endpackage

@@ sv/sast_cell.sv @@
// One session slot of the table: valid, key, timeout, countdown and a count shift bit.
module sast_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sast_pkg::t_cell_cmd   i_cmd,
    input  logic [sast_pkg::SECT_W-1:0] i_index,
    input  logic                  i_shift_in,
    output logic                  o_shift_out,
    output sast_pkg::t_cell_rd    o_rd
);

    logic                            r_valid, n_valid;
    logic                            r_key, n_key;
    logic [sast_pkg::TIME_WIDTH-1:0] r_cd, n_cd;
    logic [sast_pkg::TIME_WIDTH-1:0] r_to, n_to;
    logic                            r_live, n_live;
    logic                            hit;
    logic                            cd_nz;

    assign hit   = (i_cmd.sector == i_index);
    assign cd_nz = (r_cd != '0);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_cd    = r_cd;
        n_to    = r_to;
        n_live  = r_live;
        if (i_cmd.clear_all) begin
            n_valid = 1'b0;
        end else if (i_cmd.exec) begin
            case (i_cmd.op)
                sast_pkg::OP_MARK: begin
                    if (hit && i_cmd.mark_ok) begin
                        n_valid = 1'b1;
                        n_key   = i_cmd.key;
                        n_to    = i_cmd.timeout;
                        n_cd    = i_cmd.timeout;
                    end
                end
                sast_pkg::OP_INVALIDATE: begin
                    if (hit && i_cmd.inval_ok) n_valid = 1'b0;
                end
                sast_pkg::OP_CLEAR: begin
                    n_valid = 1'b0;
                end
                sast_pkg::OP_REFRESH: begin
                    if (hit && r_valid) n_cd = r_to;
                end
                sast_pkg::OP_SET_TIMEOUT: begin
                    if (hit && r_valid) begin
                        n_to = i_cmd.timeout;
                        n_cd = i_cmd.timeout;
                    end
                end
                sast_pkg::OP_TICK: begin
                    if (r_valid && cd_nz) n_cd = r_cd - sast_pkg::TIME_WIDTH'(1);
                end
                sast_pkg::OP_COUNT: begin
                    n_live = r_valid && cd_nz;
                end
                sast_pkg::OP_PURGE: begin
                    if (r_valid && !cd_nz) n_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.shift) begin
            n_live = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_cd   <= n_cd;
        r_to   <= n_to;
        r_live <= n_live;
    end

    assign o_shift_out  = r_live;
    assign o_rd.valid     = hit && r_valid;
    assign o_rd.key       = hit && r_key;
    assign o_rd.countdown = hit ? r_cd : '0;

endmodule

@@ sv/sector_auth_session_table.sv @@
// Top level: command sequencer and the chain of session cells.
// Sequence: a command is accepted in idle and runs in the EXEC state, at whose end
// o_done is registered; count instead goes on to the COUNT state while live bits
// shift down the cell chain. Start is taken only while o_busy is low; o_done is a
// one-cycle strobe and the receiver cannot stall. Synchronous active-low reset empties
// the table, enables caching, selects the small card and zeroes the default timeout.
module sector_auth_session_table (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [3:0]                           i_opcode,
    input  logic [sast_pkg::SECT_W-1:0]          i_sector,
    input  logic                                 i_key_b,
    input  logic [sast_pkg::FIELD_TIME_W-1:0]    i_new_timeout,
    input  logic                                 i_cfg_we,
    input  logic [sast_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sast_pkg::FIELD_TIME_W-1:0]    i_cfg_wdata,
    output logic                                 o_done,
    output logic                                 o_status,
    output logic                                 o_authenticated,
    output logic                                 o_key_matches,
    output logic                                 o_key_used,
    output logic [sast_pkg::FIELD_TIME_W-1:0]    o_time_remaining,
    output logic [sast_pkg::COUNT_W-1:0]         o_live_count
);

    sast_pkg::t_state                       r_state, n_state;
    sast_pkg::t_op                          r_op;
    logic [sast_pkg::SECT_W-1:0]            r_sector;
    logic                                   r_key;
    logic [sast_pkg::FIELD_TIME_W-1:0]      r_new_to;
    logic [sast_pkg::FIELD_TIME_W-1:0]      r_default_to;
    logic                                   r_caching;
    logic                                   r_large;
    logic [sast_pkg::COUNT_W-1:0]           r_idx, n_idx;
    logic [sast_pkg::COUNT_W-1:0]           r_cnt, n_cnt;

    logic                                   r_done, n_done;
    logic                                   r_status, n_status;
    logic                                   r_auth, n_auth;
    logic                                   r_match, n_match;
    logic                                   r_key_used, n_key_used;
    logic [sast_pkg::FIELD_TIME_W-1:0]      r_time, n_time;
    logic [sast_pkg::COUNT_W-1:0]           r_live, n_live;

    logic                                   accept;
    logic                                   sector_ok;
    sast_pkg::t_cell_cmd                    cmd;
    sast_pkg::t_cell_rd                     rd_cell [sast_pkg::MAX_SECTORS];
    logic [sast_pkg::MAX_SECTORS:0]         chain;
    sast_pkg::t_cell_rd                     rd;

    assign accept = i_start && (r_state == sast_pkg::ST_IDLE);
    assign o_busy = (r_state != sast_pkg::ST_IDLE);

    assign sector_ok = ({1'b0, r_sector} < sast_pkg::COUNT_W'(sast_pkg::MAX_SECTORS)) &&
                       (r_large ? (r_sector < sast_pkg::SECT_W'(sast_pkg::LARGE_SECTORS))
                                : (r_sector < sast_pkg::SECT_W'(sast_pkg::SMALL_SECTORS)));

    always_comb begin
        cmd.exec      = (r_state == sast_pkg::ST_EXEC);
        cmd.shift     = (r_state == sast_pkg::ST_COUNT);
        cmd.clear_all = i_cfg_we && (i_cfg_index == sast_pkg::CFG_CACHING_ENABLED) &&
                        !i_cfg_wdata[0];
        cmd.mark_ok   = sector_ok && r_caching;
        cmd.inval_ok  = sector_ok;
        cmd.op        = r_op;
        cmd.sector    = r_sector;
        cmd.key       = r_key;
        cmd.timeout   = (r_op == sast_pkg::OP_MARK) ? sast_pkg::to_time(r_default_to)
                                                    : sast_pkg::to_time(r_new_to);
    end

    assign chain[sast_pkg::MAX_SECTORS] = 1'b0;

    for (genvar gi = 0; gi < sast_pkg::MAX_SECTORS; gi++) begin : g_cell
        sast_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_index     (sast_pkg::SECT_W'(gi)),
            .i_shift_in  (chain[gi+1]),
            .o_shift_out (chain[gi]),
            .o_rd        (rd_cell[gi])
        );
    end

    always_comb begin
        rd = '0;
        for (int k = 0; k < sast_pkg::MAX_SECTORS; k++) begin
            rd = rd | rd_cell[k];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_done     = 1'b0;
        n_status   = 1'b0;
        n_auth     = 1'b0;
        n_match    = 1'b0;
        n_key_used = 1'b0;
        n_time     = '0;
        n_live     = '0;
        case (r_state)
            sast_pkg::ST_IDLE: begin
                if (accept) n_state = sast_pkg::ST_EXEC;
            end
            sast_pkg::ST_EXEC: begin
                n_state = sast_pkg::ST_IDLE;
                n_done  = 1'b1;
                case (r_op)
                    sast_pkg::OP_MARK: begin
                        n_status = !sector_ok;
                    end
                    sast_pkg::OP_QUERY: begin
                        if (rd.valid) begin
                            if (r_caching && (rd.countdown != '0)) begin
                                n_auth     = 1'b1;
                                n_match    = (rd.key == r_key);
                                n_key_used = rd.key;
                            end
                            n_time = sast_pkg::FIELD_TIME_W'(rd.countdown);
                        end
                    end
                    sast_pkg::OP_COUNT: begin
                        n_state = sast_pkg::ST_COUNT;
                        n_done  = 1'b0;
                        n_idx   = '0;
                        n_cnt   = '0;
                    end
                    default: begin
                    end
                endcase
            end
            sast_pkg::ST_COUNT: begin
                n_cnt = r_cnt + sast_pkg::COUNT_W'(chain[0]);
                n_idx = r_idx + sast_pkg::COUNT_W'(1);
                if (r_idx == sast_pkg::COUNT_W'(sast_pkg::MAX_SECTORS - 1)) begin
                    n_state = sast_pkg::ST_IDLE;
                    n_done  = 1'b1;
                    n_live  = n_cnt;
                end
            end
            default: begin
                n_state = sast_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sast_pkg::ST_IDLE;
            r_done       <= 1'b0;
            r_default_to <= '0;
            r_caching    <= 1'b1;
            r_large      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sast_pkg::CFG_DEFAULT_TIMEOUT: r_default_to <= i_cfg_wdata;
                    sast_pkg::CFG_CACHING_ENABLED: r_caching    <= i_cfg_wdata[0];
                    sast_pkg::CFG_LARGE_CARD:      r_large      <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= sast_pkg::t_op'(i_opcode);
            r_sector <= i_sector;
            r_key    <= i_key_b;
            r_new_to <= i_new_timeout;
        end
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_auth     <= n_auth;
        r_match    <= n_match;
        r_key_used <= n_key_used;
        r_time     <= n_time;
        r_live     <= n_live;
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_authenticated  = r_auth;
    assign o_key_matches    = r_match;
    assign o_key_used       = r_key_used;
    assign o_time_remaining = r_time;
    assign o_live_count     = r_live;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the sector authentication session table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  RANDOM_ITEMS = 1600;
    localparam logic [sast_pkg::FIELD_TIME_W-1:0] TIME_MAX = '1;
    localparam logic [sast_pkg::CFG_IDX_W-1:0]    CFG_UNUSED   = 2'd3;
    localparam logic [3:0]                        OP_UNUSED_LO = 4'd9;
    localparam logic [3:0]                        OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic                              status;
        logic                              authenticated;
        logic                              key_matches;
        logic                              key_used;
        logic [sast_pkg::FIELD_TIME_W-1:0] time_remaining;
        logic [sast_pkg::COUNT_W-1:0]      live_count;
    } t_reply;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_start = 1'b0;
    logic [3:0]                        i_opcode = '0;
    logic [sast_pkg::SECT_W-1:0]       i_sector = '0;
    logic                              i_key_b = 1'b0;
    logic [sast_pkg::FIELD_TIME_W-1:0] i_new_timeout = '0;
    logic                              i_cfg_we = 1'b0;
    logic [sast_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [sast_pkg::FIELD_TIME_W-1:0] i_cfg_wdata = '0;
    logic                              o_busy;
    logic                              o_done;
    logic                              o_status;
    logic                              o_authenticated;
    logic                              o_key_matches;
    logic                              o_key_used;
    logic [sast_pkg::FIELD_TIME_W-1:0] o_time_remaining;
    logic [sast_pkg::COUNT_W-1:0]      o_live_count;

    // predicted table contents and register values
    logic                            sess_valid     [sast_pkg::MAX_SECTORS];
    logic                            sess_key       [sast_pkg::MAX_SECTORS];
    logic [sast_pkg::TIME_WIDTH-1:0] sess_countdown [sast_pkg::MAX_SECTORS];
    logic [sast_pkg::TIME_WIDTH-1:0] sess_timeout   [sast_pkg::MAX_SECTORS];
    logic [sast_pkg::TIME_WIDTH-1:0] cfg_default_timeout;
    logic                            cfg_caching;
    logic                            cfg_large;

    t_reply pending_replies[$];
    t_reply head_reply;
    int     mismatches  = 0;
    int     cycle_count = 0;

    sector_auth_session_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_opcode         (i_opcode),
        .i_sector         (i_sector),
        .i_key_b          (i_key_b),
        .i_new_timeout    (i_new_timeout),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_authenticated  (o_authenticated),
        .o_key_matches    (o_key_matches),
        .o_key_used       (o_key_used),
        .o_time_remaining (o_time_remaining),
        .o_live_count     (o_live_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        $display("MISMATCH %s: expected %0h got %0h at cycle %0d", what, exp_v, got_v,
                 cycle_count);
        mismatches++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                head_reply = pending_replies.pop_front();
                if (o_status !== head_reply.status)
                    report_mismatch("status", head_reply.status, o_status);
                if (o_authenticated !== head_reply.authenticated)
                    report_mismatch("authenticated", head_reply.authenticated,
                                    o_authenticated);
                if (o_key_matches !== head_reply.key_matches)
                    report_mismatch("key_matches", head_reply.key_matches, o_key_matches);
                if (o_key_used !== head_reply.key_used)
                    report_mismatch("key_used", head_reply.key_used, o_key_used);
                if (o_time_remaining !== head_reply.time_remaining)
                    report_mismatch("time_remaining", head_reply.time_remaining,
                                    o_time_remaining);
                if (o_live_count !== head_reply.live_count)
                    report_mismatch("live_count", head_reply.live_count, o_live_count);
            end
        end
    end

    function automatic void reset_table_model();
        for (int i = 0; i < sast_pkg::MAX_SECTORS; i++) begin
            sess_valid[i]     = 1'b0;
            sess_key[i]       = 1'b0;
            sess_countdown[i] = '0;
            sess_timeout[i]   = '0;
        end
        cfg_default_timeout = '0;
        cfg_caching         = 1'b1;
        cfg_large           = 1'b0;
    endfunction

    function automatic void wipe_sessions();
        for (int i = 0; i < sast_pkg::MAX_SECTORS; i++)
            sess_valid[i] = 1'b0;
    endfunction

    function automatic t_reply apply_command(input logic [3:0] op,
                                             input logic [sast_pkg::SECT_W-1:0] sec,
                                             input logic kb,
                                             input logic [sast_pkg::FIELD_TIME_W-1:0] nt);
        t_reply r;
        int     s;
        int     live;
        logic   in_table;
        logic   sec_ok;
        r        = '{default: '0};
        in_table = (sec < sast_pkg::MAX_SECTORS);
        s        = in_table ? int'(sec) : 0;
        sec_ok   = in_table && (sec < (cfg_large ? sast_pkg::LARGE_SECTORS
                                                 : sast_pkg::SMALL_SECTORS));
        case (op)
            sast_pkg::OP_MARK: begin
                if (!sec_ok) begin
                    r.status = 1'b1;
                end else if (cfg_caching) begin
                    sess_valid[s]     = 1'b1;
                    sess_key[s]       = kb;
                    sess_timeout[s]   = cfg_default_timeout;
                    sess_countdown[s] = cfg_default_timeout;
                end
            end
            sast_pkg::OP_INVALIDATE: begin
                if (sec_ok)
                    sess_valid[s] = 1'b0;
            end
            sast_pkg::OP_CLEAR: wipe_sessions();
            sast_pkg::OP_QUERY: begin
                if (in_table && sess_valid[s]) begin
                    if (cfg_caching && sess_countdown[s] != '0) begin
                        r.authenticated = 1'b1;
                        r.key_matches   = (sess_key[s] == kb);
                        r.key_used      = sess_key[s];
                    end
                    r.time_remaining = sast_pkg::FIELD_TIME_W'(sess_countdown[s]);
                end
            end
            sast_pkg::OP_REFRESH: begin
                if (in_table && sess_valid[s])
                    sess_countdown[s] = sess_timeout[s];
            end
            sast_pkg::OP_SET_TIMEOUT: begin
                if (in_table && sess_valid[s]) begin
                    sess_timeout[s]   = sast_pkg::TIME_WIDTH'(nt);
                    sess_countdown[s] = sast_pkg::TIME_WIDTH'(nt);
                end
            end
            sast_pkg::OP_TICK: begin
                for (int i = 0; i < sast_pkg::MAX_SECTORS; i++)
                    if (sess_valid[i] && sess_countdown[i] != '0)
                        sess_countdown[i] = sess_countdown[i] - sast_pkg::TIME_WIDTH'(1);
            end
            sast_pkg::OP_COUNT: begin
                live = 0;
                for (int i = 0; i < sast_pkg::MAX_SECTORS; i++)
                    if (sess_valid[i] && sess_countdown[i] != '0)
                        live++;
                r.live_count = sast_pkg::COUNT_W'(live);
            end
            sast_pkg::OP_PURGE: begin
                for (int i = 0; i < sast_pkg::MAX_SECTORS; i++)
                    if (sess_valid[i] && sess_countdown[i] == '0)
                        sess_valid[i] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // drives one command and holds it until the block takes it
    task automatic send_command(input logic [3:0] op, input logic [sast_pkg::SECT_W-1:0] sec,
                                input logic kb,
                                input logic [sast_pkg::FIELD_TIME_W-1:0] nt = '0);
        i_start       <= 1'b1;
        i_opcode      <= op;
        i_sector      <= sec;
        i_key_b       <= kb;
        i_new_timeout <= nt;
        do @(posedge i_clk); while (o_busy);
        pending_replies.insert(pending_replies.size(), apply_command(op, sec, kb, nt));
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic write_reg(input logic [sast_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sast_pkg::FIELD_TIME_W-1:0] data);
        settle();
        while (o_busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            sast_pkg::CFG_DEFAULT_TIMEOUT: cfg_default_timeout = sast_pkg::TIME_WIDTH'(data);
            sast_pkg::CFG_CACHING_ENABLED: begin
                cfg_caching = data[0];
                if (!data[0])
                    wipe_sessions();
            end
            sast_pkg::CFG_LARGE_CARD: cfg_large = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [sast_pkg::FIELD_TIME_W-1:0] pick_timeout();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)      return sast_pkg::FIELD_TIME_W'($urandom_range(0, 6));
        else if (sel < 70) return sast_pkg::FIELD_TIME_W'($urandom_range(1, 30));
        else if (sel < 85) return sast_pkg::FIELD_TIME_W'($urandom());
        else if (sel < 95) return TIME_MAX;
        else               return '0;
    endfunction

    function automatic logic [sast_pkg::SECT_W-1:0] pick_sector();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return sast_pkg::SECT_W'($urandom_range(0, (cfg_large ? sast_pkg::LARGE_SECTORS
                                                                  : sast_pkg::SMALL_SECTORS) - 1));
        else if (sel < 80)
            return sast_pkg::SECT_W'($urandom_range(sast_pkg::SMALL_SECTORS,
                                                    sast_pkg::LARGE_SECTORS - 1));
        else
            return sast_pkg::SECT_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [3:0] pick_opcode();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 22)      return sast_pkg::OP_MARK;
        else if (sel < 46) return sast_pkg::OP_QUERY;
        else if (sel < 62) return sast_pkg::OP_TICK;
        else if (sel < 69) return sast_pkg::OP_REFRESH;
        else if (sel < 76) return sast_pkg::OP_SET_TIMEOUT;
        else if (sel < 83) return sast_pkg::OP_INVALIDATE;
        else if (sel < 88) return sast_pkg::OP_COUNT;
        else if (sel < 94) return sast_pkg::OP_PURGE;
        else if (sel < 96) return sast_pkg::OP_CLEAR;
        else               return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // empty table after reset; an entry marked with zero lifetime is never live
    task automatic test_reset_state();
        send_command(sast_pkg::OP_QUERY, 6'd0, 1'b0);
        send_command(sast_pkg::OP_MARK, 6'd0, 1'b1);
        send_command(sast_pkg::OP_QUERY, 6'd0, 1'b1);
        send_command(sast_pkg::OP_PURGE, 6'd0, 1'b0);
    endtask

    // large card, out-of-range marks, expiry and reload of an unpurged entry
    task automatic test_expiry();
        write_reg(sast_pkg::CFG_DEFAULT_TIMEOUT, TIME_MAX);
        write_reg(sast_pkg::CFG_LARGE_CARD, 20'h1);
        send_command(sast_pkg::OP_MARK, 6'd39, 1'b1);
        send_command(sast_pkg::OP_MARK, 6'd40, 1'b0);
        send_command(sast_pkg::OP_MARK, 6'd63, 1'b1);
        send_command(sast_pkg::OP_QUERY, 6'd39, 1'b1);
        send_command(sast_pkg::OP_SET_TIMEOUT, 6'd39, 1'b0, 20'h1);
        send_command(sast_pkg::OP_TICK, 6'd0, 1'b0);
        send_command(sast_pkg::OP_QUERY, 6'd39, 1'b0);
        send_command(sast_pkg::OP_COUNT, 6'd0, 1'b0);
        send_command(sast_pkg::OP_REFRESH, 6'd39, 1'b0);
        send_command(sast_pkg::OP_QUERY, 6'd39, 1'b0);
        send_command(sast_pkg::OP_QUERY, 6'd45, 1'b1);
        send_command(sast_pkg::OP_SET_TIMEOUT, 6'd45, 1'b1, TIME_MAX);
    endtask

    // entries above the small card limit stay reachable after the card shrinks
    task automatic test_card_size();
        write_reg(sast_pkg::CFG_LARGE_CARD, 20'h0);
        send_command(sast_pkg::OP_QUERY, 6'd39, 1'b1);
        send_command(sast_pkg::OP_INVALIDATE, 6'd39, 1'b0);
        send_command(sast_pkg::OP_MARK, 6'd39, 1'b0);
        send_command(sast_pkg::OP_MARK, 6'd15, 1'b0);
        send_command(OP_UNUSED_LO, 6'd15, 1'b1, TIME_MAX);
        send_command(OP_UNUSED_HI, 6'd63, 1'b1, TIME_MAX);
        send_command(sast_pkg::OP_TICK, 6'd0, 1'b0);
        send_command(sast_pkg::OP_PURGE, 6'd0, 1'b0);
        send_command(sast_pkg::OP_COUNT, 6'd0, 1'b0);
    endtask

    // caching off wipes the table and ignores marks
    task automatic test_caching_off();
        write_reg(sast_pkg::CFG_CACHING_ENABLED, 20'hABCDE);
        write_reg(CFG_UNUSED, TIME_MAX);
        send_command(sast_pkg::OP_MARK, 6'd3, 1'b1);
        send_command(sast_pkg::OP_QUERY, 6'd15, 1'b0);
        send_command(sast_pkg::OP_COUNT, 6'd0, 1'b0);
        write_reg(sast_pkg::CFG_CACHING_ENABLED, TIME_MAX);
        send_command(sast_pkg::OP_MARK, 6'd3, 1'b1);
        send_command(sast_pkg::OP_CLEAR, 6'd0, 1'b0);
        send_command(sast_pkg::OP_QUERY, 6'd3, 1'b1);
    endtask

    // random phases, each under its own register settings
    task automatic test_random_traffic();
        int sent;
        int phase;
        int phase_len;
        int burst;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       write_reg(sast_pkg::CFG_DEFAULT_TIMEOUT, '0);
                1:       write_reg(sast_pkg::CFG_DEFAULT_TIMEOUT, TIME_MAX);
                default: write_reg(sast_pkg::CFG_DEFAULT_TIMEOUT, pick_timeout());
            endcase
            write_reg(sast_pkg::CFG_LARGE_CARD, sast_pkg::FIELD_TIME_W'($urandom()));
            if (phase > 1 && $urandom_range(0, 5) == 0) begin
                write_reg(sast_pkg::CFG_CACHING_ENABLED,
                          sast_pkg::FIELD_TIME_W'($urandom()) & ~20'h1);
                phase_len = $urandom_range(20, 40);
            end else begin
                write_reg(sast_pkg::CFG_CACHING_ENABLED,
                          sast_pkg::FIELD_TIME_W'($urandom()) | 20'h1);
                phase_len = $urandom_range(100, 250);
            end
            while (phase_len > 0 && sent < RANDOM_ITEMS) begin
                burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
                while (burst > 0 && phase_len > 0 && sent < RANDOM_ITEMS) begin
                    send_command(pick_opcode(), pick_sector(), 1'($urandom()),
                                 pick_timeout());
                    burst--;
                    phase_len--;
                    sent++;
                end
                if ($urandom_range(0, 19) == 0)
                    settle();
                else if ($urandom_range(0, 9) < 7)
                    idle_for($urandom_range(1, 6));
            end
            phase++;
        end
    endtask

    initial begin
        reset_table_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_expiry();
        test_card_size();
        test_caching_off();
        test_random_traffic();
        settle();
        repeat (sast_pkg::MAX_SECTORS + 10) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
